/* sv/p4te_pkg.sv */
`default_nettype none
package p4te_pkg;

    localparam int TILE_W  = 9;
    localparam int PIXEL_W = 32;
    localparam int BYTE_W  = 8;
    localparam int ADDR_W  = 17;
    localparam int POS_W   = 5;
    localparam int SROW_W  = 3;
    localparam int NPLANES = 4;
    localparam int NUPPER  = 16;
    localparam int STORE_DEPTH = 32;
    localparam int CNT_W   = 5;

    // beat numbers inside one item's run
    localparam logic [CNT_W-1:0] BEAT_P1   = 5'd1;
    localparam logic [CNT_W-1:0] BEAT_UP0  = 5'd2;
    localparam logic [CNT_W-1:0] BEAT_LAST = 5'd17;

    // everything the beat sequencer needs to play out one row
    typedef struct packed {
        logic [BYTE_W-1:0]              plane0;
        logic [BYTE_W-1:0]              plane1;
        logic [NUPPER-1:0][BYTE_W-1:0]  upper;
        logic [ADDR_W-1:0]              base;
        logic [SROW_W-1:0]              srow;
        logic                           emit_upper;
        logic                           tile_done;
    } job_t;

endpackage
`default_nettype wire

/* sv/p4te_plane_lane.sv */
`default_nettype none
module p4te_plane_lane (
    input  wire logic [p4te_pkg::PIXEL_W-1:0] pixel_row,
    input  wire logic [1:0]                   plane_sel,
    output logic      [p4te_pkg::BYTE_W-1:0]  plane_byte
);
    import p4te_pkg::*;

    // column c goes to bit 7-c
    always_comb begin
        for (int c = 0; c < BYTE_W; c++) begin
            plane_byte[BYTE_W-1-c] = pixel_row[4*c + int'(plane_sel)];
        end
    end

endmodule
`default_nettype wire

/* sv/p4te_row_front.sv */
`default_nettype none
module p4te_row_front (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_valid,
    input  wire logic                          cfg_data,
    input  wire logic                          row_accept,
    input  wire logic [p4te_pkg::TILE_W-1:0]   tile_number,
    input  wire logic [p4te_pkg::PIXEL_W-1:0]  pixel_row,
    output p4te_pkg::job_t                     job
);
    import p4te_pkg::*;

    logic              tile_mode_reg;
    logic [POS_W-1:0]  row_position_reg;
    logic [POS_W-1:0]  row_position_next;
    logic [BYTE_W-1:0] store_reg [STORE_DEPTH];

    logic [NPLANES-1:0][BYTE_W-1:0] lane_byte;
    logic                           side;
    logic [SROW_W-1:0]              srow;

    genvar g;
    generate
        for (g = 0; g < NPLANES; g++) begin : g_lane
            p4te_plane_lane u_lane (
                .pixel_row  (pixel_row),
                .plane_sel  (2'(g)),
                .plane_byte (lane_byte[g])
            );
        end
    endgenerate

    always_comb begin
        if (tile_mode_reg) begin
            side = row_position_reg[0];
            srow = row_position_reg[3:1];
            job.base = {1'b0, tile_number[8:3], row_position_reg[4], tile_number[2:0],
                        side, 5'b0};
            job.tile_done = (row_position_reg == POS_W'(31));
            row_position_next = row_position_reg + POS_W'(1);
        end else begin
            side = 1'b0;
            srow = row_position_reg[2:0];
            job.base = {3'b0, tile_number, 5'b0};
            job.tile_done = (srow == SROW_W'(7));
            row_position_next = {2'b0, srow + SROW_W'(1)};
        end
        job.srow       = srow;
        job.emit_upper = (srow == SROW_W'(7));
        job.plane0     = lane_byte[0];
        job.plane1     = lane_byte[1];
        // rows 0..6 of this side come from the store, row 7 from the lanes
        for (int k = 0; k < NUPPER - 2; k++) begin
            job.upper[k] = store_reg[{side, 4'(k)}];
        end
        job.upper[NUPPER-2] = lane_byte[2];
        job.upper[NUPPER-1] = lane_byte[3];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tile_mode_reg    <= 1'b0;
            row_position_reg <= '0;
        end else if (cfg_valid) begin
            tile_mode_reg    <= cfg_data;
            row_position_reg <= '0;
        end else if (row_accept) begin
            row_position_reg <= row_position_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (row_accept) begin
            store_reg[{side, srow, 1'b0}] <= lane_byte[2];
            store_reg[{side, srow, 1'b1}] <= lane_byte[3];
        end
    end

endmodule
`default_nettype wire

/* sv/p4te_beat_sequencer.sv */
`default_nettype none
module p4te_beat_sequencer (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire p4te_pkg::job_t                job_in,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [p4te_pkg::BYTE_W-1:0]        m_plane_byte,
    output logic [p4te_pkg::ADDR_W-1:0]        m_byte_address,
    output logic                               m_run_last,
    output logic                               m_tile_end
);
    import p4te_pkg::*;

    job_t              job_reg;
    logic              job_valid_reg;
    logic [CNT_W-1:0]  cnt_reg;

    logic              m_valid_reg;
    logic [BYTE_W-1:0] byte_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic              run_last_reg;
    logic              tile_end_reg;

    logic              out_free;
    logic              fire;
    logic              last_beat;
    logic [CNT_W-1:0]  up_idx;
    logic [BYTE_W-1:0] beat_byte;
    logic [4:0]        beat_offset;

    assign out_free  = !m_valid_reg || m_ready;
    assign fire      = job_valid_reg && out_free;
    assign last_beat = job_reg.emit_upper ? (cnt_reg == BEAT_LAST) : (cnt_reg == BEAT_P1);
    assign s_ready   = !job_valid_reg || (fire && last_beat);
    assign up_idx    = cnt_reg - BEAT_UP0;

    always_comb begin
        if (cnt_reg == '0) begin
            beat_byte   = job_reg.plane0;
            beat_offset = {1'b0, job_reg.srow, 1'b0};
        end else if (cnt_reg == BEAT_P1) begin
            beat_byte   = job_reg.plane1;
            beat_offset = {1'b0, job_reg.srow, 1'b1};
        end else begin
            beat_byte   = job_reg.upper[up_idx[3:0]];
            beat_offset = {1'b1, up_idx[3:0]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            job_valid_reg <= 1'b0;
            cnt_reg       <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                job_valid_reg <= 1'b1;
                cnt_reg       <= '0;
            end else if (fire && last_beat) begin
                job_valid_reg <= 1'b0;
            end else if (fire) begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            if (fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            job_reg <= job_in;
        end
        if (fire) begin
            byte_reg     <= beat_byte;
            addr_reg     <= job_reg.base | {12'b0, beat_offset};
            run_last_reg <= last_beat;
            tile_end_reg <= last_beat && job_reg.emit_upper && job_reg.tile_done;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_plane_byte   = byte_reg;
    assign m_byte_address = addr_reg;
    assign m_run_last     = run_last_reg;
    assign m_tile_end     = tile_end_reg;

endmodule
`default_nettype wire

/* sv/planar_4bpp_tile_encoder_top.sv */
// Planar 4bpp tile encoder.
// s_ channel: one beat per pixel row (8x8 mode) or half-row (16x16 mode),
//   s_tile_number selects the tile, s_pixel_row holds eight 4-bit pixels.
// m_ channel: one bitplane byte per beat with its byte address. m_run_last
//   marks the final beat of an input row, m_tile_end the final byte of a tile.
// cfg channel: cfg_data writes tile_mode (0 = 8x8, 1 = 16x16) and restarts
//   the row count; write it only while the block is idle. cfg_ready is always high.
// Four plane lanes split a row combinationally; the plane 2/3 bytes go to a
// 32-byte store and are played out when a subtile's last row arrives.
// Each accepted row waits in the job register; its bytes are registered
// again on the way out. The output carries one byte per cycle while m_ready
// is high: 2 bytes for an ordinary row, 18 for the row that closes a subtile,
// 4 bytes per row on average. A new row is accepted in the cycle its
// predecessor's last byte leaves the job register, so rows stream back to back.
// Reset sets 8x8 mode and row 0; the store needs no clearing.
// When m_ready is low, output and job register hold and s_ready drops once
// the job register is full.
`default_nettype none
module planar_4bpp_tile_encoder_top (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic                          cfg_data,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [p4te_pkg::TILE_W-1:0]   s_tile_number,
    input  wire logic [p4te_pkg::PIXEL_W-1:0]  s_pixel_row,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [p4te_pkg::BYTE_W-1:0]        m_plane_byte,
    output logic [p4te_pkg::ADDR_W-1:0]        m_byte_address,
    output logic                               m_run_last,
    output logic                               m_tile_end
);
    import p4te_pkg::*;

    job_t job;

    assign cfg_ready = 1'b1;

    p4te_row_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_valid   (cfg_valid),
        .cfg_data    (cfg_data),
        .row_accept  (s_valid && s_ready),
        .tile_number (s_tile_number),
        .pixel_row   (s_pixel_row),
        .job         (job)
    );

    p4te_beat_sequencer u_seq (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .job_in         (job),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_plane_byte   (m_plane_byte),
        .m_byte_address (m_byte_address),
        .m_run_last     (m_run_last),
        .m_tile_end     (m_tile_end)
    );

endmodule
`default_nettype wire

/* bench/tile_byte_checker.sv */
module tile_byte_checker
    import p4te_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                cfg_valid,
    input  wire logic                cfg_ready,
    input  wire logic                cfg_data,
    input  wire logic                s_valid,
    input  wire logic                s_ready,
    input  wire logic [TILE_W-1:0]   s_tile_number,
    input  wire logic [PIXEL_W-1:0]  s_pixel_row,
    input  wire logic                m_valid,
    input  wire logic                m_ready,
    input  wire logic [BYTE_W-1:0]   m_plane_byte,
    input  wire logic [ADDR_W-1:0]   m_byte_address,
    input  wire logic                m_run_last,
    input  wire logic                m_tile_end,
    output int                       mismatches,
    output int                       pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [BYTE_W-1:0] plane_byte;
        logic [ADDR_W-1:0] byte_address;
        logic              run_last;
        logic              tile_end;
    } plane_beat_t;

    plane_beat_t        expected_beats[$];
    logic               quad_mode;
    logic [POS_W-1:0]   next_row;
    logic [BYTE_W-1:0]  held_upper[STORE_DEPTH];

    // column 0 (bits 3..0) lands in bit 7
    function automatic logic [BYTE_W-1:0] plane_bits(input logic [PIXEL_W-1:0] px,
                                                     input int plane);
        logic [BYTE_W-1:0] b;
        for (int c = 0; c < 8; c++)
            b[7-c] = px[4*c+plane];
        return b;
    endfunction

    function automatic plane_beat_t make_beat(input logic [BYTE_W-1:0] data,
                                              input logic [ADDR_W-1:0] addr,
                                              input logic last, input logic tend);
        plane_beat_t b;
        b.plane_byte   = data;
        b.byte_address = addr;
        b.run_last     = last;
        b.tile_end     = tend;
        return b;
    endfunction

    task automatic predict_row(input logic [TILE_W-1:0] tile, input logic [PIXEL_W-1:0] px);
        logic [POS_W-1:0]  h;
        logic [3:0]        row;
        logic              side;
        logic [SROW_W-1:0] srow;
        logic [ADDR_W-1:0] base;
        logic              done;
        logic              emit;
        logic [4:0]        slot;
        if (quad_mode) begin
            h    = next_row;
            row  = h[4:1];
            side = h[0];
            srow = row[2:0];
            // (tile%8)*64 + (tile/8)*0x400 + lower-half 0x200 + right-side 32
            base = {1'b0, tile[8:3], row[3], tile[2:0], side, 5'b0};
            done = (h == 5'd31);
            next_row = h + 5'd1;
        end else begin
            side = 1'b0;
            srow = next_row[SROW_W-1:0];
            base = {3'b0, tile, 5'b0};
            done = (srow == 3'd7);
            next_row = {2'b0, srow + 3'd1};
        end
        emit = (srow == 3'd7);
        slot = {side, srow, 1'b0};
        held_upper[slot]      = plane_bits(px, 2);
        held_upper[slot+5'd1] = plane_bits(px, 3);
        expected_beats.push_back(make_beat(plane_bits(px, 0), ADDR_W'(base + 2*srow),
                                           1'b0, 1'b0));
        expected_beats.push_back(make_beat(plane_bits(px, 1), ADDR_W'(base + 2*srow + 1),
                                           !emit, 1'b0));
        if (emit) begin
            for (int k = 0; k < NUPPER; k++)
                expected_beats.push_back(make_beat(held_upper[{side, 4'(k)}],
                                                   ADDR_W'(base + 16 + k),
                                                   k == NUPPER-1, (k == NUPPER-1) && done));
        end
    endtask

    task automatic compare_field(input string field, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, field, want, got);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin : monitor
        plane_beat_t want;
        if (!aresetn) begin
            quad_mode = 1'b0;
            next_row  = '0;
            expected_beats.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (expected_beats.size() == 0) begin
                    $display("%0t: unexpected beat, expected none actual addr %0h data %0h",
                             $time, m_byte_address, m_plane_byte);
                    mismatches++;
                end else begin
                    want = expected_beats.pop_front();
                    compare_field("plane_byte", 32'(want.plane_byte), 32'(m_plane_byte));
                    compare_field("byte_address", 32'(want.byte_address),
                                  32'(m_byte_address));
                    compare_field("run_last", 32'(want.run_last), 32'(m_run_last));
                    compare_field("tile_end", 32'(want.tile_end), 32'(m_tile_end));
                end
            end
            if (cfg_valid && cfg_ready) begin
                quad_mode = cfg_data;
                next_row  = '0;
            end
            if (s_valid && s_ready)
                predict_row(s_tile_number, s_pixel_row);
        end
        pending = expected_beats.size();
    end

endmodule

/* bench/testbench.sv */
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import p4te_pkg::*;

    localparam logic MODE_8X8   = 1'b0;
    localparam logic MODE_16X16 = 1'b1;
    localparam int   STALL_LIMIT = 2000;
    localparam int   ROW_TARGET  = 310;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic                cfg_data = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    logic [TILE_W-1:0]   s_tile_number = '0;
    logic [PIXEL_W-1:0]  s_pixel_row = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    logic [BYTE_W-1:0]   m_plane_byte;
    logic [ADDR_W-1:0]   m_byte_address;
    logic                m_run_last;
    logic                m_tile_end;

    int   mismatches;
    int   pending;
    bit   feed_quiet = 1'b0;
    bit   sink_quiet = 1'b0;
    int   sink_wait = 0;
    int   idle_cycles = 0;

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    planar_4bpp_tile_encoder_top dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_tile_number(s_tile_number), .s_pixel_row(s_pixel_row),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_plane_byte(m_plane_byte), .m_byte_address(m_byte_address),
        .m_run_last(m_run_last), .m_tile_end(m_tile_end)
    );

    tile_byte_checker byte_checker (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_tile_number(s_tile_number), .s_pixel_row(s_pixel_row),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_plane_byte(m_plane_byte), .m_byte_address(m_byte_address),
        .m_run_last(m_run_last), .m_tile_end(m_tile_end),
        .mismatches(mismatches), .pending(pending)
    );

    // result side: after each beat, drop ready at random unless sink_quiet is set
    always @(posedge aclk) begin : sink_ctl
        int gap;
        if (!aresetn) begin
            m_ready   <= 1'b0;
            sink_wait <= 0;
        end else if (!m_ready) begin
            if (sink_wait <= 1)
                m_ready <= 1'b1;
            else
                sink_wait <= sink_wait - 1;
        end else if (m_valid) begin
            gap = sink_quiet ? 0 : $urandom_range(0, 6);
            if (gap != 0) begin
                m_ready   <= 1'b0;
                sink_wait <= gap;
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("** planar_4bpp_tile_encoder_top: FAILED **");
                $finish;
            end
        end
    end

    function automatic logic [TILE_W-1:0] pick_tile();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            default: return TILE_W'($urandom_range(0, 511));
        endcase
    endfunction

    function automatic logic [PIXEL_W-1:0] pick_pixels();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_row(input logic [TILE_W-1:0] tile, input logic [PIXEL_W-1:0] px);
        int gap;
        gap = feed_quiet ? 0 : $urandom_range(0, 6);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_tile_number <= tile;
        s_pixel_row   <= px;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    task automatic write_mode(input logic mode);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= mode;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    initial begin : stimulus
        logic [PIXEL_W-1:0] patterns[8];
        logic [TILE_W-1:0]  tile;
        int rows_sent;
        int phase;
        int rows_per_tile;
        int ntiles;
        logic mode;

        patterns = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h1111_1111, 32'h2222_2222,
                     32'h4444_4444, 32'h8888_8888, 32'h7654_3210, 32'hFEDC_BA98};
        rows_sent = 0;
        phase = 0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // 8x8 tile whose number changes halfway through
        for (int r = 0; r < 8; r++) begin
            send_row(r < 4 ? 9'd0 : 9'd511, patterns[r]);
            rows_sent++;
        end
        // unfinished tile, then a mode switch restarts the row count
        send_row(9'd1, 32'hA5A5_A5A5);
        send_row(9'd1, 32'h5A5A_5A5A);
        rows_sent += 2;
        write_mode(MODE_16X16);
        // upper quadrants of the highest tile, both sides closed
        for (int h = 0; h < 16; h++) begin
            send_row(9'd511, patterns[h % 8] ^ {8{4'(h)}});
            rows_sent++;
        end

        while (rows_sent < ROW_TARGET) begin
            mode = (phase < 2) ? (phase == 0 ? MODE_8X8 : MODE_16X16)
                               : 1'($urandom_range(0, 1));
            write_mode(mode);
            feed_quiet = ($urandom_range(0, 3) == 0);
            sink_quiet = ($urandom_range(0, 3) == 0);
            rows_per_tile = (mode == MODE_16X16) ? 32 : 8;
            ntiles = (mode == MODE_16X16) ? $urandom_range(1, 2) : $urandom_range(1, 5);
            for (int t = 0; t < ntiles; t++) begin
                tile = pick_tile();
                for (int r = 0; r < rows_per_tile; r++) begin
                    // now and then a stray tile number inside a tile
                    send_row(($urandom_range(0, 15) == 0) ? pick_tile() : tile, pick_pixels());
                    rows_sent++;
                end
                if ($urandom_range(0, 4) == 0)
                    drain();
            end
            // leave the tile unfinished before the next mode write
            if ($urandom_range(0, 2) == 0) begin
                tile = pick_tile();
                repeat ($urandom_range(1, rows_per_tile - 1)) begin
                    send_row(tile, pick_pixels());
                    rows_sent++;
                end
            end
            phase++;
        end

        drain();
        repeat (20) @(posedge aclk);
        if (mismatches == 0 && pending == 0)
            $display("** planar_4bpp_tile_encoder_top: PASSED **");
        else
            $display("** planar_4bpp_tile_encoder_top: FAILED **");
        $finish;
    end

endmodule

/* files.f */
sv/p4te_pkg.sv
sv/p4te_plane_lane.sv
sv/p4te_row_front.sv
sv/p4te_beat_sequencer.sv
sv/planar_4bpp_tile_encoder_top.sv
bench/tile_byte_checker.sv
bench/testbench.sv
